@@ rtl/nearest_palette_color_top_macros.svh @@
// Assertion macros for the nearest palette color block.
// Included by the top level; depends on nothing else.
`ifndef NEAREST_PALETTE_COLOR_TOP_MACROS_SVH
`define NEAREST_PALETTE_COLOR_TOP_MACROS_SVH

// Checks that a condition implies another in the same cycle.
`define NPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nearest palette color: same-cycle check failed");

// Checks that a condition implies another in the following cycle.
`define NPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nearest palette color: next-cycle check failed");

`endif

@@ rtl/npc_pkg.sv @@
// Shared types and constants for the nearest palette color block.
// Used by the controller, the datapath and the top level; no dependencies.
package npc_pkg;

  localparam int PALETTE_SIZE = 256;
  localparam int IDX_W        = 8;
  localparam int COLOR_W      = 8;
  localparam int SQ_W         = 2 * COLOR_W;
  localparam int DIST_W       = 18;
  localparam int COUNT_W      = 9;
  localparam int ENTRY_W      = 3 * COLOR_W;

  localparam logic [COUNT_W-1:0] COUNT_RESET  = COUNT_W'(PALETTE_SIZE);
  localparam logic [COUNT_W-1:0] COUNT_LIMIT  = COUNT_W'(PALETTE_SIZE);
  localparam logic [DIST_W-1:0]  MAX_DIST     = DIST_W'(195075);

  // Request kinds carried on the input user field.
  localparam logic REQ_LOAD     = 1'b0;
  localparam logic REQ_CLASSIFY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             pal_we;
    logic             latch_query;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_first;
    logic             rd_last;
    logic             publish;
  } npc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } npc_stat_t;

endpackage

@@ rtl/nearest_palette_color_top.sv @@
// Nearest palette color block. A load item (req_type 0) writes one palette entry. A
// classify item (req_type 1) searches entries 0 to N-1, where N is palette_count with
// zero read as one and values above 256 read as 256, and returns the index and squared
// distance of the closest entry, lowest index on ties. While a classify item occupies the
// block, the single read port of the palette memory delivers one entry per cycle into a
// three-stage distance and compare pipeline. The result sits in
// an output register, so new items are taken while it waits. Entries must be loaded before
// a classify searches them. Depends on npc_pkg, npc_ctrl, npc_datapath and the macro header.
`include "nearest_palette_color_top_macros.svh"

module nearest_palette_color_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // entry_index, red, green, blue
  input  logic                        in_tuser,   // req_type
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,  // best_index, best_distance, zero pad
  input  logic                        cfg_we,
  input  logic [npc_pkg::COUNT_W-1:0] cfg_wdata   // palette_count
);
  import npc_pkg::*;

  npc_cmd_t          cmd;
  npc_stat_t         stat;
  logic [IDX_W-1:0]  best_index;
  logic [DIST_W-1:0] best_distance;

  npc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_req_type (in_tuser),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .stat        (stat)
  );

  npc_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .entry_index       (in_tdata[7:0]),
    .red               (in_tdata[15:8]),
    .green             (in_tdata[23:16]),
    .blue              (in_tdata[31:24]),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_best_index    (best_index),
    .out_best_distance (best_distance)
  );

  // Result packing: index in the low byte, distance above it.
  assign out_tdata = {6'b0, best_distance, best_index};

  // A result is never published over one that has not been taken.
  `NPC_ASSERT_NOW(a_publish_free, clk, rst_n, cmd.publish, !out_tvalid || out_tready)
  // A classify transfer closes the input until its result is published.
  `NPC_ASSERT_NEXT(a_classify_busy, clk, rst_n, in_tvalid && in_tready && in_tuser, !in_tready)
  // A result appears only after the controller publishes one.
  `NPC_ASSERT_NOW(a_valid_from_publish, clk, rst_n, $rose(out_tvalid), $past(cmd.publish))
  // A delivered distance never exceeds the largest possible squared distance.
  `NPC_ASSERT_NOW(a_dist_range, clk, rst_n, out_tvalid, best_distance <= MAX_DIST)

endmodule

@@ rtl/npc_ctrl.sv @@
// Controller for the nearest palette color block: handshake, count register, scan sequencing.
// Depends on npc_pkg.
module npc_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic                        in_req_type,
  input  logic                        cfg_we,
  input  logic [npc_pkg::COUNT_W-1:0] cfg_wdata,
  output npc_pkg::npc_cmd_t           cmd,
  input  npc_pkg::npc_stat_t          stat
);
  import npc_pkg::*;

  state_t             state_r, state_nxt;
  logic [COUNT_W-1:0] count_r;
  logic [IDX_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]   last_idx;
  logic               accept;
  logic               scan_last;

  // Highest entry searched: a count of zero searches entry zero, a large count saturates.
  always_comb begin
    if (count_r == '0) begin
      last_idx = '0;
    end else if (count_r > COUNT_LIMIT) begin
      last_idx = IDX_W'(COUNT_LIMIT - COUNT_W'(1));
    end else begin
      last_idx = IDX_W'(count_r - COUNT_W'(1));
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign scan_last = (scan_idx_r == last_idx);

  // Next state and scan counter.
  always_comb begin
    state_nxt    = state_r;
    scan_idx_nxt = scan_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        scan_idx_nxt = '0;
        if (accept && (in_req_type == REQ_CLASSIFY)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_idx_nxt = scan_idx_r + IDX_W'(1);
        if (scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (stat.scan_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd.pal_we      = accept && (in_req_type == REQ_LOAD);
    cmd.latch_query = accept && (in_req_type == REQ_CLASSIFY);
    cmd.rd_en       = (state_r == ST_SCAN);
    cmd.rd_addr     = scan_idx_r;
    cmd.rd_first    = (scan_idx_r == '0);
    cmd.rd_last     = scan_last;
    cmd.publish     = (state_r == ST_FIN) && stat.out_free;
  end

  // State, counter and count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_idx_r <= '0;
      count_r    <= COUNT_RESET;
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
    end
  end

endmodule

@@ rtl/npc_datapath.sv @@
// Datapath for the nearest palette color block: palette memory, distance pipeline,
// best-match tracking and output register. Depends on npc_pkg.
module npc_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  npc_pkg::npc_cmd_t            cmd,
  output npc_pkg::npc_stat_t           stat,
  input  logic [npc_pkg::IDX_W-1:0]    entry_index,
  input  logic [npc_pkg::COLOR_W-1:0]  red,
  input  logic [npc_pkg::COLOR_W-1:0]  green,
  input  logic [npc_pkg::COLOR_W-1:0]  blue,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [npc_pkg::IDX_W-1:0]    out_best_index,
  output logic [npc_pkg::DIST_W-1:0]   out_best_distance
);
  import npc_pkg::*;

  logic [ENTRY_W-1:0] pal_mem [PALETTE_SIZE];
  logic [ENTRY_W-1:0] rd_data_r;

  logic [COLOR_W-1:0] q_red_r, q_green_r, q_blue_r;

  // Pipeline tags: stage 1 read data, stage 2 squares, stage 3 distance.
  logic             v1_r, v2_r, v3_r;
  logic             first1_r, first2_r, first3_r;
  logic             last1_r, last2_r, last3_r;
  logic [IDX_W-1:0] idx1_r, idx2_r, idx3_r;

  logic [COLOR_W-1:0] dr, dg, db;
  logic [SQ_W-1:0]    sq_r_r, sq_g_r, sq_b_r;
  logic [DIST_W-1:0]  dist_r;

  logic [IDX_W-1:0]   best_idx_r;
  logic [DIST_W-1:0]  best_dist_r;
  logic               take;

  logic               out_valid_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic [DIST_W-1:0]  out_dist_r;

  function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                  input logic [COLOR_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // Palette memory: one write port for loads, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (cmd.pal_we) begin
      pal_mem[entry_index] <= {blue, green, red};
    end
    if (cmd.rd_en) begin
      rd_data_r <= pal_mem[cmd.rd_addr];
    end
  end

  // Query color is held for the whole scan.
  always_ff @(posedge clk) begin
    if (cmd.latch_query) begin
      q_red_r   <= red;
      q_green_r <= green;
      q_blue_r  <= blue;
    end
  end

  assign dr = abs_diff(q_red_r,   rd_data_r[COLOR_W-1:0]);
  assign dg = abs_diff(q_green_r, rd_data_r[2*COLOR_W-1:COLOR_W]);
  assign db = abs_diff(q_blue_r,  rd_data_r[3*COLOR_W-1:2*COLOR_W]);

  // Squares, then their sum.
  always_ff @(posedge clk) begin
    sq_r_r <= SQ_W'(dr) * SQ_W'(dr);
    sq_g_r <= SQ_W'(dg) * SQ_W'(dg);
    sq_b_r <= SQ_W'(db) * SQ_W'(db);
    dist_r <= DIST_W'(sq_r_r) + DIST_W'(sq_g_r) + DIST_W'(sq_b_r);
  end

  // Tags follow the data through the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    first1_r <= cmd.rd_first;
    last1_r  <= cmd.rd_last;
    idx1_r   <= cmd.rd_addr;
    first2_r <= first1_r;
    last2_r  <= last1_r;
    idx2_r   <= idx1_r;
    first3_r <= first2_r;
    last3_r  <= last2_r;
    idx3_r   <= idx2_r;
  end

  // Only a strictly smaller distance replaces the best, so ties keep the lowest index.
  assign take = v3_r && (first3_r || (dist_r < best_dist_r));

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx_r  <= idx3_r;
      best_dist_r <= dist_r;
    end
  end

  // Output register: the result waits here while the block takes new items.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.publish) begin
      out_idx_r  <= best_idx_r;
      out_dist_r <= best_dist_r;
    end
  end

  assign stat.scan_done   = v3_r && last3_r;
  assign stat.out_free    = !out_valid_r || out_tready;
  assign out_tvalid        = out_valid_r;
  assign out_best_index    = out_idx_r;
  assign out_best_distance = out_dist_r;

endmodule
